[rtl/core/sncag_pkg.sv]
// Shared types, constants and register codes for the strided N-dimensional
// copy address generator. No dependencies; every other file depends on this.

package sncag_pkg;

	// Default sizes, handed to the top-level and queue parameters
	localparam int unsigned MAX_DIMS_DEF    = 4;
	localparam int unsigned EXTENT_BITS_DEF = 16;
	localparam int unsigned ADDR_BITS_DEF   = 32;
	localparam int unsigned QUEUE_DEPTH     = 4;

	// Configuration port geometry
	localparam int unsigned CFG_DATA_BITS   = 64;
	localparam int unsigned CFG_IDX_BITS    = 3;
	localparam int unsigned DIM_COUNT_BITS  = 3;
	localparam int unsigned ELEM_BYTES_BITS = 8;

	// Register reset values
	localparam logic [DIM_COUNT_BITS-1:0]  DIM_COUNT_RST  = DIM_COUNT_BITS'(1);
	localparam logic [CFG_DATA_BITS-1:0]   EXTENTS_RST    = 64'h0001_0001_0001_0001;
	localparam logic [CFG_DATA_BITS-1:0]   STRIDES_RST    = '0;
	localparam logic [ELEM_BYTES_BITS-1:0] ELEM_BYTES_RST = ELEM_BYTES_BITS'(1);

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DIM_COUNT   = 3'd0,
		REG_EXTENTS     = 3'd1,
		REG_SRC_STRIDES = 3'd2,
		REG_DST_STRIDES = 3'd3,
		REG_ELEM_BYTES  = 3'd4
	} cfg_reg_t;

	// Current register contents, shared by front and back
	typedef struct packed {
		logic [DIM_COUNT_BITS-1:0]  dim_count;
		logic [CFG_DATA_BITS-1:0]   extents;
		logic [CFG_DATA_BITS-1:0]   src_strides;
		logic [CFG_DATA_BITS-1:0]   dst_strides;
		logic [ELEM_BYTES_BITS-1:0] element_bytes;
	} cfg_t;

	// Queue fill status seen by both of its neighbours
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/core/sncag_if.sv]
// Valid/ready channel interfaces for the copy address generator: the job
// channel (restart flag and base addresses) and the address pair channel.
// Depends on sncag_pkg for default widths.

interface sncag_job_if #(
	parameter int unsigned ADDR_BITS = sncag_pkg::ADDR_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic                 restart;
	logic [ADDR_BITS-1:0] src_base;
	logic [ADDR_BITS-1:0] dst_base;

	modport source (output valid, restart, src_base, dst_base, input ready);
	modport sink   (input valid, restart, src_base, dst_base, output ready);
endinterface

interface sncag_addr_if #(
	parameter int unsigned ADDR_BITS = sncag_pkg::ADDR_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] read_addr;
	logic [ADDR_BITS-1:0] write_addr;
	logic                 last;

	modport source (output valid, read_addr, write_addr, last, input ready);
	modport sink   (input valid, read_addr, write_addr, last, output ready);
endinterface

[rtl/core/strided_nd_copy_address_generator.sv]
// Strided N-dimensional copy address generator, top level.
// Path: a job's address pair passes the queue and the products, sum, scale and
// output registers; idle and zero-extent jobs produce no transfer at all.
// Throughput: one job per cycle while the queue is not full, set by the odometer
// and fully pipelined back end; output stalls back up through the 4-entry queue.
// Reset: registers take their defaults, the index clears, idle until a restart.

module strided_nd_copy_address_generator #(
	parameter int unsigned MAX_DIMS    = sncag_pkg::MAX_DIMS_DEF,
	parameter int unsigned EXTENT_BITS = sncag_pkg::EXTENT_BITS_DEF,
	parameter int unsigned ADDR_BITS   = sncag_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sncag_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [sncag_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sncag_job_if.sink                           job,
	sncag_addr_if.source                        addr_pair
);
	import sncag_pkg::*;

	localparam int unsigned IDX_W = MAX_DIMS * EXTENT_BITS;
	localparam int unsigned Q_W   = IDX_W + 2 * ADDR_BITS + 1;

	cfg_t                 cfg_q;
	q_status_t            q_status;
	logic                 q_push;
	logic                 q_pop;
	logic                 push_last;
	logic [IDX_W-1:0]     push_idx;
	logic [Q_W-1:0]       q_wdata;
	logic [Q_W-1:0]       q_rdata;

	// Register file: take writes, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_count     <= DIM_COUNT_RST;
			cfg_q.extents       <= EXTENTS_RST;
			cfg_q.src_strides   <= STRIDES_RST;
			cfg_q.dst_strides   <= STRIDES_RST;
			cfg_q.element_bytes <= ELEM_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_DIM_COUNT:   cfg_q.dim_count     <= DIM_COUNT_BITS'(cfg_data);
				REG_EXTENTS:     cfg_q.extents       <= cfg_data;
				REG_SRC_STRIDES: cfg_q.src_strides   <= cfg_data;
				REG_DST_STRIDES: cfg_q.dst_strides   <= cfg_data;
				REG_ELEM_BYTES:  cfg_q.element_bytes <= ELEM_BYTES_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	sncag_front #(
		.MAX_DIMS    (MAX_DIMS),
		.EXTENT_BITS (EXTENT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.job_valid   (job.valid),
		.job_ready   (job.ready),
		.job_restart (job.restart),
		.q_status    (q_status),
		.push        (q_push),
		.push_last   (push_last),
		.push_idx    (push_idx)
	);

	assign q_wdata = {push_idx, job.src_base, job.dst_base, push_last};

	sncag_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	sncag_back #(
		.MAX_DIMS    (MAX_DIMS),
		.EXTENT_BITS (EXTENT_BITS),
		.ADDR_BITS   (ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_status   (q_status),
		.pop        (q_pop),
		.q_idx      (q_rdata[Q_W-1 -: IDX_W]),
		.q_src_base (q_rdata[2*ADDR_BITS -: ADDR_BITS]),
		.q_dst_base (q_rdata[ADDR_BITS -: ADDR_BITS]),
		.q_last     (q_rdata[0]),
		.out_valid  (addr_pair.valid),
		.out_ready  (addr_pair.ready),
		.read_addr  (addr_pair.read_addr),
		.write_addr (addr_pair.write_addr),
		.last       (addr_pair.last)
	);

	// Front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue push while full");

	// Back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue pop while empty");

	// A restart on a one-dimensional non-empty shape always emits an element
	a_restart_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.ready && job.restart
			&& cfg_q.dim_count == DIM_COUNT_BITS'(1)
			&& cfg_q.extents[EXTENT_BITS-1:0] != '0) |-> q_push)
		else $error("restart transfer produced no element");

endmodule

[rtl/core/sncag_front.sv]
// Front end: takes job transfers, runs the odometer over the configured shape
// and pushes one index snapshot per emitted element into the queue.
// Depends on sncag_pkg.

module sncag_front #(
	parameter int unsigned MAX_DIMS    = sncag_pkg::MAX_DIMS_DEF,
	parameter int unsigned EXTENT_BITS = sncag_pkg::EXTENT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sncag_pkg::cfg_t                 cfg,
	input  logic                            job_valid,
	output logic                            job_ready,
	input  logic                            job_restart,
	input  sncag_pkg::q_status_t            q_status,
	output logic                            push,
	output logic                            push_last,
	output logic [MAX_DIMS*EXTENT_BITS-1:0] push_idx
);
	import sncag_pkg::*;

	logic [EXTENT_BITS-1:0] idx_q     [MAX_DIMS];
	logic [EXTENT_BITS-1:0] idx_eff   [MAX_DIMS];
	logic [EXTENT_BITS-1:0] idx_next  [MAX_DIMS];
	logic [EXTENT_BITS-1:0] ext       [MAX_DIMS];
	logic [EXTENT_BITS-1:0] ext_eff   [MAX_DIMS];
	logic [MAX_DIMS-1:0]    used;
	logic [MAX_DIMS-1:0]    lt;
	logic                   done_q;
	logic                   done_eff;
	logic                   any_zero;
	logic                   is_last;
	logic                   carry;
	logic                   emit;
	logic                   accept;

	// Slice the packed extents; fields beyond the register read as zero
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
		if (d * EXTENT_BITS < CFG_DATA_BITS) begin : g_in
			assign ext[d] = EXTENT_BITS'(cfg.extents >> (d * EXTENT_BITS));
		end else begin : g_out
			assign ext[d] = '0;
		end
		assign used[d]    = cfg.dim_count > DIM_COUNT_BITS'(d);
		assign ext_eff[d] = used[d] ? ext[d] : EXTENT_BITS'(1);
	end

	assign job_ready = !q_status.full;
	assign accept    = job_valid && job_ready;

	// Classify the transfer and work out the next multi-index
	always_comb begin
		done_eff = job_restart ? 1'b0 : done_q;
		any_zero = 1'b0;
		is_last  = 1'b1;
		carry    = 1'b1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			idx_eff[d] = job_restart ? '0 : idx_q[d];
			if (used[d] && ext[d] == '0) begin
				any_zero = 1'b1;
			end
			lt[d] = ({1'b0, idx_eff[d]} + 1'b1) < {1'b0, ext_eff[d]};
			if (lt[d]) begin
				is_last = 1'b0;
			end
		end
		// Ripple the carry from dimension 0 upward
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (carry) begin
				idx_next[d] = lt[d] ? EXTENT_BITS'(idx_eff[d] + 1'b1) : '0;
			end else begin
				idx_next[d] = idx_eff[d];
			end
			carry = carry && !lt[d];
		end
		emit = !done_eff && !any_zero;
		for (int d = 0; d < MAX_DIMS; d++) begin
			push_idx[d*EXTENT_BITS +: EXTENT_BITS] = used[d] ? idx_eff[d] : '0;
		end
	end

	assign push      = accept && emit;
	assign push_last = is_last;

	// Hold the odometer (a restart clears it); advance only on an emitted element that is not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
			for (int d = 0; d < MAX_DIMS; d++) begin
				idx_q[d] <= '0;
			end
		end else if (accept) begin
			done_q <= done_eff || any_zero || is_last;
			for (int d = 0; d < MAX_DIMS; d++) begin
				idx_q[d] <= (emit && !is_last) ? idx_next[d] : idx_eff[d];
			end
		end
	end

endmodule

[rtl/core/sncag_queue.sv]
// Short first-in first-out queue that decouples the odometer front end from
// the address arithmetic back end. Depends on sncag_pkg.

module sncag_queue #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = sncag_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  pop,
	output logic [WIDTH-1:0]      rdata,
	output sncag_pkg::q_status_t  status
);
	import sncag_pkg::*;

	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign status.full  = count_q == (PTR_BITS+1)'(DEPTH);
	assign status.empty = count_q == '0;
	assign rdata        = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/sncag_back.sv]
// Back end: turns queued index snapshots into source and destination byte
// addresses through a four-stage pipeline (products, sum, scale, base add).
// Depends on sncag_pkg.

module sncag_back #(
	parameter int unsigned MAX_DIMS    = sncag_pkg::MAX_DIMS_DEF,
	parameter int unsigned EXTENT_BITS = sncag_pkg::EXTENT_BITS_DEF,
	parameter int unsigned ADDR_BITS   = sncag_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sncag_pkg::cfg_t                 cfg,
	input  sncag_pkg::q_status_t            q_status,
	output logic                            pop,
	input  logic [MAX_DIMS*EXTENT_BITS-1:0] q_idx,
	input  logic [ADDR_BITS-1:0]            q_src_base,
	input  logic [ADDR_BITS-1:0]            q_dst_base,
	input  logic                            q_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ADDR_BITS-1:0]            read_addr,
	output logic [ADDR_BITS-1:0]            write_addr,
	output logic                            last
);
	import sncag_pkg::*;

	logic signed [EXTENT_BITS-1:0] src_stride [MAX_DIMS];
	logic signed [EXTENT_BITS-1:0] dst_stride [MAX_DIMS];
	logic signed [2*EXTENT_BITS:0] src_prod   [MAX_DIMS];
	logic signed [2*EXTENT_BITS:0] dst_prod   [MAX_DIMS];

	logic [ADDR_BITS-1:0] src_prod_s1 [MAX_DIMS];
	logic [ADDR_BITS-1:0] dst_prod_s1 [MAX_DIMS];
	logic [ADDR_BITS-1:0] src_base_s1, dst_base_s1;
	logic                 last_s1, valid_s1;

	logic [ADDR_BITS-1:0] src_sum, dst_sum;
	logic [ADDR_BITS-1:0] src_sum_s2, dst_sum_s2;
	logic [ADDR_BITS-1:0] src_base_s2, dst_base_s2;
	logic                 last_s2, valid_s2;

	logic [ADDR_BITS-1:0] src_off_s3, dst_off_s3;
	logic [ADDR_BITS-1:0] src_base_s3, dst_base_s3;
	logic                 last_s3, valid_s3;

	logic [ADDR_BITS-1:0] read_addr_q, write_addr_q;
	logic                 last_q, out_valid_q;
	logic                 adv;

	// Slice signed strides and form the per-dimension products
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
		if (d * EXTENT_BITS < CFG_DATA_BITS) begin : g_in
			assign src_stride[d] = EXTENT_BITS'(cfg.src_strides >> (d * EXTENT_BITS));
			assign dst_stride[d] = EXTENT_BITS'(cfg.dst_strides >> (d * EXTENT_BITS));
		end else begin : g_out
			assign src_stride[d] = '0;
			assign dst_stride[d] = '0;
		end
		assign src_prod[d] = $signed({1'b0, q_idx[d*EXTENT_BITS +: EXTENT_BITS]})
			* src_stride[d];
		assign dst_prod[d] = $signed({1'b0, q_idx[d*EXTENT_BITS +: EXTENT_BITS]})
			* dst_stride[d];
	end

	// Whole pipeline moves while the output register is free or being drained
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !q_status.empty;

	// Sum the products of one element
	always_comb begin
		src_sum = '0;
		dst_sum = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			src_sum = src_sum + src_prod_s1[d];
			dst_sum = dst_sum + dst_prod_s1[d];
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !q_status.empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				src_prod_s1[d] <= ADDR_BITS'(src_prod[d]);
				dst_prod_s1[d] <= ADDR_BITS'(dst_prod[d]);
			end
			src_base_s1  <= q_src_base;
			dst_base_s1  <= q_dst_base;
			last_s1      <= q_last;

			src_sum_s2   <= src_sum;
			dst_sum_s2   <= dst_sum;
			src_base_s2  <= src_base_s1;
			dst_base_s2  <= dst_base_s1;
			last_s2      <= last_s1;

			src_off_s3   <= ADDR_BITS'(src_sum_s2 * ADDR_BITS'(cfg.element_bytes));
			dst_off_s3   <= ADDR_BITS'(dst_sum_s2 * ADDR_BITS'(cfg.element_bytes));
			src_base_s3  <= src_base_s2;
			dst_base_s3  <= dst_base_s2;
			last_s3      <= last_s2;

			read_addr_q  <= src_base_s3 + src_off_s3;
			write_addr_q <= dst_base_s3 + dst_off_s3;
			last_q       <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_addr  = read_addr_q;
	assign write_addr = write_addr_q;
	assign last       = last_q;

endmodule
